/* rtl/dsp_pkg.sv */
// ----------------------------------------------------------------------------
// dsp_pkg: shared constants and types for the DAG shortest path engine
// Holds the result kinds, operation codes and register indexes.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int DefMaxNodes = 32;
  localparam int DefMaxEdges = 256;
  localparam int NodeW = 6;
  localparam int DistW = 7;
  localparam logic [DistW-1:0] DistUnreached = 7'd127;

  typedef enum logic [1:0] {
    KIND_COUNT      = 2'd0,
    KIND_NODE       = 2'd1,
    KIND_IMPOSSIBLE = 2'd2
  } result_kind_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE     = 2'd1;
  localparam logic [1:0] REG_TARGET     = 2'd2;

endpackage

/* rtl/dag_shortest_path_engine.sv */
// ----------------------------------------------------------------------------
// dag_shortest_path_engine: unit-weight shortest path on a loaded DAG
//
// Channel  | Signals                                  | Payload
// s_axis   | s_axis_tvalid/tready/tdata/tuser         | operation (tuser), edge_from, edge_to
// m_axis   | m_axis_tvalid/tready/tdata/tuser/tlast   | result_value, result_kind
// cfg      | cfg_valid/ready/index/data               | node_count, source, target
//
// A solve sweeps the edge store once per step: one in-degree pass, one pass
// per dequeued node, one per relaxed node and one per path hop. The edge
// memory read port is registered and paces every pass. Reset is synchronous
// and needs no clearing pass. Results wait in one output register; the
// sequencer stalls while it is full and not being taken.
// ----------------------------------------------------------------------------
module dag_shortest_path_engine
  import dsp_pkg::*;
#(
  parameter int MAX_NODES = DefMaxNodes,
  parameter int MAX_EDGES = DefMaxEdges
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] edge_from, [11:6] edge_to
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] result_value
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int QW = $clog2(MAX_NODES + 1);
  localparam int IW = $clog2(MAX_NODES);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DEG   = 10'b0000000010,
    ST_SEED  = 10'b0000000100,
    ST_KAHN  = 10'b0000001000,
    ST_FIND  = 10'b0000010000,
    ST_RELAX = 10'b0000100000,
    ST_EMIT  = 10'b0001000000,
    ST_WALK  = 10'b0010000000,
    ST_LAST  = 10'b0100000000,
    ST_WAIT  = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [NodeW-1:0] node_count, source_node, target_node;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NodeW'(1);
      source_node <= NodeW'(1);
      target_node <= NodeW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count <= cfg_data;
        REG_SOURCE:     source_node <= cfg_data;
        REG_TARGET:     target_node <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective node count.
  logic [NodeW-1:0] n_eff;
  always_comb begin
    if (node_count == '0) n_eff = NodeW'(1);
    else if (32'(node_count) > MAX_NODES) n_eff = NodeW'(MAX_NODES);
    else n_eff = node_count;
  end

  // Edge memory, read data registered.
  logic [2*NodeW-1:0] edge_mem [MAX_EDGES];
  logic [EW-1:0] edges_loaded;
  logic [EW-1:0] eidx;
  logic [2*NodeW-1:0] erd;
  logic eread_ok;
  logic load_go;

  assign s_axis_tready = (state == ST_IDLE);
  assign load_go = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOAD)
                   && (32'(edges_loaded) < MAX_EDGES);

  always_ff @(posedge clk) begin
    if (load_go) edge_mem[edges_loaded[AW-1:0]] <= s_axis_tdata[11:0];
    erd <= edge_mem[eidx[AW-1:0]];
  end

  // Node tables in flip-flops; indeg and dist_tbl are indexed by node number minus one, topo by queue position.
  logic [EW-1:0]    indeg    [MAX_NODES];
  logic [DistW-1:0] dist_tbl [MAX_NODES];
  logic [NodeW-1:0] topo     [MAX_NODES];

  logic [QW-1:0] qh, qt, ipos;
  logic [NodeW-1:0] cur, seed;
  logic phase;  // 0: issue read, 1: data valid
  logic [NodeW-1:0] et, eh;
  logic usable;
  logic out_full;
  logic found;

  assign et = erd[NodeW-1:0];
  assign eh = erd[2*NodeW-1:NodeW];
  assign usable = eread_ok && et != '0 && et <= n_eff && eh != '0 && eh <= n_eff;

  logic [IW-1:0] hh;
  assign hh = IW'(eh - NodeW'(1));

  // Output register.
  logic [1:0] o_kind;
  logic [NodeW-1:0] o_val;
  logic o_last;
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = {2'b00, o_val};
  assign m_axis_tuser = o_kind;
  assign m_axis_tlast = o_last;

  logic sweep_end;
  assign sweep_end = (eidx == edges_loaded);

  logic [DistW-1:0] dcur;
  assign dcur = dist_tbl[IW'(cur - NodeW'(1))];

  // Sequencer: each sweep presents edge eidx to the registered read port and reads the edge back from it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      edges_loaded <= '0;
      out_full <= 1'b0;
      eidx <= '0;
      eread_ok <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (out_full && m_axis_tready) out_full <= 1'b0;
      eread_ok <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (load_go) edges_loaded <= edges_loaded + EW'(1);
          if (s_axis_tvalid && s_axis_tuser == OP_SOLVE) begin
            for (int i = 0; i < MAX_NODES; i++) begin
              indeg[i] <= '0;
              dist_tbl[i] <= DistUnreached;
            end
            eidx <= '0;
            state <= ST_DEG;
          end
        end
        ST_DEG: begin
          if (usable) indeg[hh] <= indeg[hh] + EW'(1);
          if (sweep_end) begin
            if (!eread_ok) begin
              seed <= NodeW'(1);
              qt <= '0;
              qh <= '0;
              state <= ST_SEED;
            end
          end else begin
            eidx <= eidx + EW'(1);
            eread_ok <= 1'b1;
          end
        end
        ST_SEED: begin
          if (indeg[IW'(seed - NodeW'(1))] == '0) begin
            topo[qt[IW-1:0]] <= seed;
            qt <= qt + QW'(1);
          end
          if (seed == n_eff) begin
            phase <= 1'b0;
            state <= ST_KAHN;
          end else seed <= seed + NodeW'(1);
        end
        ST_KAHN: begin
          if (!phase) begin
            if (qh == qt) begin
              ipos <= '0;
              seed <= '0;
              state <= ST_FIND;
            end else begin
              cur <= topo[qh[IW-1:0]];
              qh <= qh + QW'(1);
              eidx <= '0;
              phase <= 1'b1;
            end
          end else begin
            if (usable && et == cur && indeg[hh] != '0) begin
              indeg[hh] <= indeg[hh] - EW'(1);
              if (indeg[hh] == EW'(1)) begin
                topo[qt[IW-1:0]] <= eh;
                qt <= qt + QW'(1);
              end
            end
            if (sweep_end) begin
              if (!eread_ok) phase <= 1'b0;
            end else begin
              eidx <= eidx + EW'(1);
              eread_ok <= 1'b1;
            end
          end
        end
        ST_FIND: begin
          // Check outcome, locate target's position in the order.
          if (qt != QW'(n_eff) || source_node == '0 || source_node > n_eff
              || target_node == '0 || target_node > n_eff) begin
            state <= ST_LAST;
            found <= 1'b0;
          end else if (seed == NodeW'(0)) begin
            seed <= NodeW'(1);
            dist_tbl[IW'(target_node - NodeW'(1))] <= '0;
          end else begin
            if (topo[IW'(seed - NodeW'(1))] == target_node) ipos <= QW'(seed - NodeW'(1));
            if (seed == n_eff) begin
              phase <= 1'b0;
              state <= ST_RELAX;
            end else seed <= seed + NodeW'(1);
          end
        end
        ST_RELAX: begin
          if (!phase) begin
            if (ipos == '0) begin
              if (dist_tbl[IW'(source_node - NodeW'(1))] == DistUnreached) begin
                found <= 1'b0;
                state <= ST_LAST;
              end else state <= ST_EMIT;
            end else begin
              cur <= topo[IW'(ipos - QW'(1))];
              ipos <= ipos - QW'(1);
              eidx <= '0;
              phase <= 1'b1;
            end
          end else begin
            if (usable && et == cur && dist_tbl[hh] != DistUnreached
                && dist_tbl[hh] + DistW'(1) < dcur)
              dist_tbl[IW'(cur - NodeW'(1))] <= dist_tbl[hh] + DistW'(1);
            if (sweep_end) begin
              if (!eread_ok) phase <= 1'b0;
            end else begin
              eidx <= eidx + EW'(1);
              eread_ok <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (!out_full) begin
            out_full <= 1'b1;
            o_kind <= KIND_COUNT;
            o_val <= NodeW'(dist_tbl[IW'(source_node - NodeW'(1))] + DistW'(1));
            o_last <= 1'b0;
            cur <= source_node;
            seed <= '0;
            found <= 1'b1;
            phase <= 1'b0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!phase) begin
            if (cur == target_node || seed == n_eff) state <= ST_LAST;
            else if (!out_full || m_axis_tready) begin
              out_full <= 1'b1;
              o_kind <= KIND_NODE;
              o_val <= cur;
              o_last <= 1'b0;
              eidx <= '0;
              found <= 1'b0;
              phase <= 1'b1;
            end
          end else begin
            if (!found && usable && et == cur && dist_tbl[hh] != DistUnreached
                && dist_tbl[hh] + DistW'(1) == dcur) begin
              found <= 1'b1;
              cur <= eh;
            end
            if (sweep_end) begin
              if (!eread_ok) begin
                phase <= 1'b0;
                seed <= seed + NodeW'(1);
                // A dead end still closes the path with the target node.
                if (!found) begin
                  found <= 1'b1;
                  state <= ST_LAST;
                end
              end
            end else begin
              eidx <= eidx + EW'(1);
              eread_ok <= 1'b1;
            end
          end
        end
        ST_LAST: begin
          if (!out_full || m_axis_tready) begin
            out_full <= 1'b1;
            o_last <= 1'b1;
            if (found) begin
              o_kind <= KIND_NODE;
              o_val <= target_node;
            end else begin
              o_kind <= KIND_IMPOSSIBLE;
              o_val <= '0;
            end
            edges_loaded <= '0;
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!out_full || m_axis_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The edge store never exceeds its capacity.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    32'(edges_loaded) <= MAX_EDGES) else $error("edge count overflow");
  // An impossible result always closes the solve.
  a_imp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_IMPOSSIBLE |-> m_axis_tlast)
    else $error("impossible not last");
  // The count result is never marked last.
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_COUNT |-> !m_axis_tlast)
    else $error("count marked last");
  // Input is held off while a solve runs.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_axis_tready) else $error("ready while busy");
`endif

endmodule

/* test/dag_shortest_path_engine_tb.sv */
// ----------------------------------------------------------------------------
// dag_shortest_path_engine_tb: self-checking bench for the DAG path engine
// Loads edge lists and solves them across several register settings and
// idling phases, predicting each path and checking results in order.
// ----------------------------------------------------------------------------
module dag_shortest_path_engine_tb;
  import dsp_pkg::*;

  localparam int NMax = 32;
  localparam int EMax = 256;

  typedef struct packed {
    result_kind_t kind;
    logic [5:0]   value;
    logic         last;
  } path_result_t;

  // Path predictor and queue of pending results.
  class path_board;
    logic [5:0] nodes_reg, src_reg, dst_reg;
    logic [5:0] tails[EMax];
    logic [5:0] heads[EMax];
    int         edge_cnt;
    path_result_t pending[$];
    int         errors;

    function new();
      nodes_reg = 1; src_reg = 1; dst_reg = 1; edge_cnt = 0; errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [5:0] val);
      if (idx == REG_NODE_COUNT) nodes_reg = val;
      else if (idx == REG_SOURCE) src_reg = val;
      else if (idx == REG_TARGET) dst_reg = val;
    endfunction

    function bit usable(int e, int n);
      return tails[e] >= 1 && tails[e] <= n && heads[e] >= 1 && heads[e] <= n;
    endfunction

    function void push(result_kind_t k, int v, bit l);
      path_result_t r;
      r.kind = k; r.value = v[5:0]; r.last = l;
      pending = {pending, r};
    endfunction

    // Note one accepted input transaction.
    function void note_input(logic op, logic [5:0] from, logic [5:0] to);
      int n, qh, qt, pos, cur, nxt, steps;
      int indeg[NMax+1];
      int dist_tbl[NMax+1];
      int order[NMax];
      if (op == OP_LOAD) begin
        if (edge_cnt < EMax) begin
          tails[edge_cnt] = from; heads[edge_cnt] = to; edge_cnt++;
        end
        return;
      end
      n = nodes_reg;
      if (n == 0) n = 1;
      if (n > NMax) n = NMax;
      for (int i = 0; i <= NMax; i++) begin
        indeg[i] = 0; dist_tbl[i] = 127;
      end
      for (int e = 0; e < edge_cnt; e++)
        if (usable(e, n)) indeg[heads[e]]++;
      qh = 0; qt = 0;
      for (int i = 1; i <= n; i++)
        if (indeg[i] == 0) order[qt++] = i;
      while (qh < qt) begin
        cur = order[qh++];
        for (int e = 0; e < edge_cnt; e++)
          if (usable(e, n) && tails[e] == cur && indeg[heads[e]] > 0) begin
            indeg[heads[e]]--;
            if (indeg[heads[e]] == 0 && qt < NMax) order[qt++] = heads[e];
          end
      end
      if (qt != n || src_reg < 1 || src_reg > n || dst_reg < 1 || dst_reg > n) begin
        push(KIND_IMPOSSIBLE, 0, 1); edge_cnt = 0; return;
      end
      pos = 0;
      for (int i = 0; i < n; i++) if (order[i] == dst_reg) pos = i;
      dist_tbl[dst_reg] = 0;
      // Relax in reverse topological order from the target's position.
      for (int i = pos; i > 0; i--) begin
        cur = order[i-1];
        for (int e = 0; e < edge_cnt; e++)
          if (usable(e, n) && tails[e] == cur && dist_tbl[heads[e]] != 127 &&
              dist_tbl[heads[e]] + 1 < dist_tbl[cur])
            dist_tbl[cur] = dist_tbl[heads[e]] + 1;
      end
      if (dist_tbl[src_reg] == 127) begin
        push(KIND_IMPOSSIBLE, 0, 1); edge_cnt = 0; return;
      end
      push(KIND_COUNT, dist_tbl[src_reg] + 1, 0);
      cur = src_reg;
      for (steps = 0; steps < n; steps++) begin
        if (cur == dst_reg) break;
        push(KIND_NODE, cur, 0);
        nxt = 0;
        for (int e = 0; e < edge_cnt; e++)
          if (usable(e, n) && tails[e] == cur && dist_tbl[heads[e]] != 127 &&
              dist_tbl[heads[e]] + 1 == dist_tbl[cur]) begin
            nxt = heads[e];
            break;
          end
        if (nxt == 0) break;
        cur = nxt;
      end
      push(KIND_NODE, dst_reg, 1);
      edge_cnt = 0;
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    function void check_result(logic [1:0] kind, logic [5:0] value, logic last);
      path_result_t x;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d value=%0d last=%0d", kind, value, last);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (kind !== x.kind) begin
        $error("result_kind expected %0d actual %0d", x.kind, kind); errors++;
      end
      if (value !== x.value) begin
        $error("result_value expected %0d actual %0d", x.value, value); errors++;
      end
      if (last !== x.last) begin
        $error("last_result expected %0d actual %0d", x.last, last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  path_board board = new();

  dag_shortest_path_engine dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      board.note_input(s_axis_tuser[0], s_axis_tdata[5:0], s_axis_tdata[11:6]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser, m_axis_tdata[5:0], m_axis_tlast);
  end

  // Receiver stalls at random on each falling edge.
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Valid stays up after the transaction until the next item or an idle gap.
  task automatic send_item(logic op, logic [5:0] from, logic [5:0] to);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0, to, from};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Registers are only written with the engine idle.
  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_graph(logic [5:0] n, logic [5:0] s, logic [5:0] t);
    drain();
    write_reg(REG_NODE_COUNT, n);
    write_reg(REG_SOURCE, s);
    write_reg(REG_TARGET, t);
    cfg_valid <= 0;
  endtask

  // A random layered DAG (edges go from lower to higher node) with optional noise, then a solve.
  task automatic random_graph(int n, int n_edges, bit allow_noise);
    int a, b;
    for (int i = 0; i < n_edges; i++) begin
      a = $urandom_range(n - 1, 1);
      b = $urandom_range(n, a + 1);
      if (allow_noise && $urandom_range(9) == 0) begin
        a = $urandom_range(63); b = $urandom_range(63);
      end
      send_item(OP_LOAD, a[5:0], b[5:0]);
    end
    send_item(OP_SOLVE, 6'($urandom), 6'($urandom));
  endtask

  initial begin
    int n, s, t, tmp;
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: trivial graph with reset registers, source equals target.
    send_item(OP_SOLVE, 6'd0, 6'd0);
    set_graph(6'd4, 6'd1, 6'd4);
    send_item(OP_LOAD, 6'd1, 6'd2);
    send_item(OP_LOAD, 6'd2, 6'd4);
    send_item(OP_LOAD, 6'd1, 6'd3);
    send_item(OP_LOAD, 6'd3, 6'd4);
    send_item(OP_LOAD, 6'd63, 6'd0);
    send_item(OP_SOLVE, 6'd63, 6'd63);
    // Cycle gives impossible.
    send_item(OP_LOAD, 6'd2, 6'd3);
    send_item(OP_LOAD, 6'd3, 6'd2);
    send_item(OP_SOLVE, 6'd0, 6'd0);
    // Self loop.
    send_item(OP_LOAD, 6'd1, 6'd1);
    send_item(OP_SOLVE, 6'd0, 6'd0);
    // Unreachable target.
    send_item(OP_LOAD, 6'd2, 6'd3);
    send_item(OP_SOLVE, 6'd0, 6'd0);
    // Node count zero and source or target out of range.
    set_graph(6'd0, 6'd1, 6'd1);
    send_item(OP_SOLVE, 6'd0, 6'd0);
    set_graph(6'd63, 6'd0, 6'd32);
    send_item(OP_SOLVE, 6'd0, 6'd0);
    // Long chain on the full node range.
    set_graph(6'd32, 6'd1, 6'd32);
    for (int i = 1; i < 32; i++) send_item(OP_LOAD, i[5:0], 6'(i + 1));
    send_item(OP_SOLVE, 6'd0, 6'd0);

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 15 : 77) : 0;
      recv_stall_pct = (ph == 2) ? 77 : (ph == 3 ? 15 : 0);
      for (int g = 0; g < 2; g++) begin
        n = (g == 0 && ph == 3) ? 32 : $urandom_range(8, 2);
        s = $urandom_range(n);
        t = $urandom_range(n);
        if ($urandom_range(3) != 0 && s > t) begin
          tmp = s; s = t; t = tmp;
        end
        set_graph(n[5:0], s[5:0], t[5:0]);
        random_graph(n, $urandom_range(6, 2), 1);
        random_graph(n, $urandom_range(6, 2), 0);
        if (g == 0) drain();
      end
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* dag_shortest_path_engine.f */
rtl/dsp_pkg.sv
rtl/dag_shortest_path_engine.sv
test/dag_shortest_path_engine_tb.sv
